### hdl/sss_pkg.sv
// Package for the sorted-matrix staircase search unit.
// Holds sizing defaults, control/status structs and the microcode table.
// No dependencies.
`default_nettype none

package sss_pkg;

  localparam int SSS_MAX_ROWS   = 16;
  localparam int SSS_MAX_COLS   = 16;
  localparam int SSS_DATA_WIDTH = 32;

  // Configuration register byte addresses (one bit decodes them)
  localparam logic [2:0] ADDR_ROWS_IN_USE = 3'd0;
  localparam logic [2:0] ADDR_COLS_IN_USE = 3'd4;
  localparam logic [4:0] ROWS_RESET       = 5'd4;
  localparam logic [4:0] COLS_RESET       = 5'd4;

  // Program steps
  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_START = 2'd1;
  localparam step_t STEP_WALK  = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_GO    = 2'd0,
    COND_EMPTY = 2'd1,
    COND_STOP  = 2'd2,
    COND_SLOT  = 2'd3
  } cond_t;

  // Datapath controls decoded from one microcode word
  typedef struct packed {
    logic take;
    logic rd_init;
    logic walk;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t jump;
    step_t next;
  } uword_t;

  // Datapath status for the jump conditions
  typedef struct packed {
    logic go;
    logic empty;
    logic stop;
  } path_stat_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.ctrl.take = 1'b1;
        w.cond = COND_GO;    w.jump = STEP_START; w.next = STEP_IDLE;
      end
      STEP_START: begin
        w.ctrl.rd_init = 1'b1;
        w.cond = COND_EMPTY; w.jump = STEP_EMIT;  w.next = STEP_WALK;
      end
      STEP_WALK: begin
        w.ctrl.walk = 1'b1;
        w.cond = COND_STOP;  w.jump = STEP_EMIT;  w.next = STEP_WALK;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond = COND_SLOT;  w.jump = STEP_IDLE;  w.next = STEP_EMIT;
      end
      default: begin
        w.cond = COND_GO;    w.jump = STEP_IDLE;  w.next = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/sss_useq.sv
// Microcode sequencer: step counter, control word table and jump select.
// Depends on sss_pkg.
`default_nettype none

module sss_useq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sss_pkg::path_stat_t stat,
  input  wire logic               slot_free,
  output sss_pkg::ctrl_t          ctrl
);

  sss_pkg::step_t  step;
  sss_pkg::step_t  step_next;
  sss_pkg::uword_t word;
  logic            cond_true;

  assign word = sss_pkg::ucode(step);
  assign ctrl = word.ctrl;

  always_comb begin
    case (word.cond)
      sss_pkg::COND_GO:    cond_true = stat.go;
      sss_pkg::COND_EMPTY: cond_true = stat.empty;
      sss_pkg::COND_STOP:  cond_true = stat.stop;
      sss_pkg::COND_SLOT:  cond_true = slot_free;
      default:             cond_true = 1'b0;
    endcase
    step_next = cond_true ? word.jump : word.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sss_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### hdl/sss_dpath.sv
// Datapath: matrix memory, walk position counters, compare and result flag.
// Depends on sss_pkg.
`default_nettype none

module sss_dpath #(
  parameter int MAX_ROWS   = sss_pkg::SSS_MAX_ROWS,
  parameter int MAX_COLS   = sss_pkg::SSS_MAX_COLS,
  parameter int DATA_WIDTH = sss_pkg::SSS_DATA_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sss_pkg::ctrl_t     ctrl,
  input  wire logic [4:0]         rows_in_use,
  input  wire logic [4:0]         cols_in_use,
  input  wire logic               in_valid,
  input  wire logic               action,
  input  wire logic [3:0]         row_index,
  input  wire logic [3:0]         col_index,
  input  wire logic signed [31:0] item_value,
  output sss_pkg::path_stat_t     stat,
  output logic                    hit_flag
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] key;
  logic [RCW-1:0]        r;
  logic [CCW-1:0]        cnt;
  logic [AW-1:0]         addr;

  logic [31:0]           rows_w, cols_w, init_w, dn_w, lf_w, wa_w;
  logic [RCW-1:0]        rows_eff;
  logic [CCW-1:0]        cols_eff;
  logic signed [63:0]    val64;
  logic [DATA_WIDTH-1:0] key_in;
  logic                  accept, we, hit, less, last_row, last_col, stop;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr, addr_dn, addr_lf;

  // Saturate the counts at the store size
  assign rows_w = (32'(rows_in_use) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(rows_in_use);
  assign cols_w = (32'(cols_in_use) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cols_in_use);
  assign rows_eff = rows_w[RCW-1:0];
  assign cols_eff = cols_w[CCW-1:0];

  assign val64  = 64'(item_value);
  assign key_in = val64[DATA_WIDTH-1:0];

  assign accept = in_valid & ctrl.take;
  assign we     = accept & ~action
                & (32'(row_index) < 32'(MAX_ROWS)) & (32'(col_index) < 32'(MAX_COLS));
  assign wa_w   = 32'(row_index) * 32'(MAX_COLS) + 32'(col_index);

  // Compare the fetched element with the key
  assign hit      = (rdata == key);
  assign less     = $signed(rdata) < $signed(key);
  assign last_row = (32'(r) + 32'd1) == 32'(rows_eff);
  assign last_col = (cnt == CCW'(1));
  assign stop     = hit | (less ? last_row : last_col);

  assign init_w  = 32'(cols_eff) - 32'd1;
  assign dn_w    = 32'(addr) + 32'(MAX_COLS);
  assign lf_w    = 32'(addr) - 32'd1;
  assign addr_dn = dn_w[AW-1:0];
  assign addr_lf = lf_w[AW-1:0];

  assign rd_en   = ctrl.rd_init | (ctrl.walk & ~stop);
  assign rd_addr = ctrl.rd_init ? addr : (less ? addr_dn : addr_lf);

  assign stat.go    = accept & action;
  assign stat.empty = (rows_eff == '0) | (cols_eff == '0);
  assign stat.stop  = stop;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa_w[AW-1:0]] <= key_in;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Load the walk on a search item, then advance one step per compare
  always_ff @(posedge clk) begin
    if (stat.go) begin
      key  <= key_in;
      r    <= '0;
      cnt  <= cols_eff;
      addr <= init_w[AW-1:0];
    end else if (ctrl.walk && !hit) begin
      if (less) begin
        r    <= r + RCW'(1);
        addr <= addr_dn;
      end else begin
        cnt  <= cnt - CCW'(1);
        addr <= addr_lf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_flag <= 1'b0;
    end else if (ctrl.rd_init) begin
      hit_flag <= 1'b0;
    end else if (ctrl.walk && stop) begin
      hit_flag <= hit;
    end
  end

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    we |-> ctrl.take)
    else $error("matrix write outside idle step");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.walk |-> !stat.empty)
    else $error("walk running on an empty matrix");

endmodule

`default_nettype wire

### hdl/sorted_matrix_staircase_search_unit.sv
// Top level of the sorted-matrix staircase search unit.
// Holds the config registers and output register; uses sss_pkg, sss_useq, sss_dpath.
`default_nettype none

//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+----------------------------------
//  config    | in        | psel/penable/pwrite/pready | paddr, pwdata (prdata on reads)
//  request   | in        | in_valid / in_ready        | action, row_index, col_index,
//            |           |                            | item_value
//  result    | out       | out_valid / out_ready      | found (one per search item)
//
//  A write item is stored at its accept edge. A search item passes the start step,
//  one walk step per compare (1 .. rows+cols-1 compares, so up to 31 at 16x16) and the
//  emit step; one compare per cycle, set by the single read port of the matrix memory
//  feeding the walk step. An empty matrix goes from the start step straight to emit.
//  Reset clears the step counter, the output valid bit and the counts (4 and 4);
//  the matrix memory is not cleared. A full output register stalls only the emit step.

module sorted_matrix_staircase_search_unit #(
  parameter int MAX_ROWS   = sss_pkg::SSS_MAX_ROWS,
  parameter int MAX_COLS   = sss_pkg::SSS_MAX_COLS,
  parameter int DATA_WIDTH = sss_pkg::SSS_DATA_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic [3:0]         row_index,
  input  wire logic [3:0]         col_index,
  input  wire logic signed [31:0] item_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found
);

  sss_pkg::ctrl_t      ctrl;
  sss_pkg::path_stat_t stat;
  logic [4:0]          rows_in_use;
  logic [4:0]          cols_in_use;
  logic                slot_free;
  logic                hit_flag;
  logic                cfg_wr;

  // Config port: zero-wait, decode on the word bit only
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == sss_pkg::ADDR_COLS_IN_USE[2]) ? {27'd0, cols_in_use}
                                                             : {27'd0, rows_in_use};

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= sss_pkg::ROWS_RESET;
      cols_in_use <= sss_pkg::COLS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == sss_pkg::ADDR_COLS_IN_USE[2]) begin
        cols_in_use <= pwdata[4:0];
      end else begin
        rows_in_use <= pwdata[4:0];
      end
    end
  end

  // Take a request only while the program sits in its idle step
  assign in_ready  = ctrl.take;
  assign slot_free = ~out_valid | out_ready;

  sss_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .slot_free (slot_free),
    .ctrl      (ctrl)
  );

  sss_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .in_valid    (in_valid),
    .action      (action),
    .row_index   (row_index),
    .col_index   (col_index),
    .item_value  (item_value),
    .stat        (stat),
    .hit_flag    (hit_flag)
  );

  // Output register: load on the emit step once the slot is free, drop on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && slot_free) begin
      found <= hit_flag;
    end
  end

  a_search_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action) |=> (!in_ready && ctrl.rd_init))
    else $error("search item did not start the walk");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !action) |=> in_ready)
    else $error("write item left the idle step");

  a_emit_loads_result: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && slot_free) |=> (out_valid && in_ready))
    else $error("emit step did not load the result");

endmodule

`default_nettype wire

### verif/staircase_checker.sv
// Result checker for the sorted-matrix staircase search unit, plus the item codes it shares
// with the testbench top. Depends on sss_pkg for sizes, register addresses and reset counts.
package staircase_tb_pkg;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SEARCH = 1'b1
  } action_e;

endpackage

module staircase_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic [3:0]         row_index,
  input  logic [3:0]         col_index,
  input  logic signed [31:0] item_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               found,
  input  logic               drained,
  output int                 failures
);
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;
  import staircase_tb_pkg::*;

  logic signed [31:0] cells [SSS_MAX_ROWS*SSS_MAX_COLS];
  logic [4:0]         rows_cfg;
  logic [4:0]         cols_cfg;
  logic               found_q [$];
  int                 errors;
  bit                 leftover_told;

  // Walk from the top-right cell in use: down when the cell is smaller, left otherwise.
  function automatic logic staircase_walk(input logic signed [31:0] target);
    int nrows;
    int ncols;
    int r;
    int c;
    logic signed [31:0] e;
    nrows = (rows_cfg > SSS_MAX_ROWS) ? SSS_MAX_ROWS : int'(rows_cfg);
    ncols = (cols_cfg > SSS_MAX_COLS) ? SSS_MAX_COLS : int'(cols_cfg);
    r = 0;
    c = ncols - 1;
    while (r < nrows && c >= 0) begin
      e = cells[r*SSS_MAX_COLS + c];
      if (e == target) return 1'b1;
      if (e < target) r++;
      else c--;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      found_q.delete();
      errors = 0;
      leftover_told = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_ROWS_IN_USE) rows_cfg = pwdata[4:0];
        else if (paddr == ADDR_COLS_IN_USE) cols_cfg = pwdata[4:0];
      end
      if (out_valid && out_ready) begin
        if (found_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result with no search pending: found=%b", found);
        end else begin
          want = found_q.pop_front();
          if (found !== want) begin
            errors++;
            if (errors <= 10) $display("found mismatch: expected %b, actual %b", want, found);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_SEARCH) found_q.push_back(staircase_walk(item_value));
        else cells[row_index*SSS_MAX_COLS + col_index] = item_value;
      end
      if (drained && !leftover_told && found_q.size() != 0) begin
        leftover_told = 1'b1;
        $display("%0d searches left without a result", found_q.size());
      end
    end
    failures <= errors + found_q.size();
  end

endmodule

### verif/testbench.sv
// Testbench top for the sorted-matrix staircase search unit: drives reset, the APB port and
// both item channels, and gives the verdict. Depends on sss_pkg, staircase_tb_pkg and the checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;
  import staircase_tb_pkg::*;

  localparam int                 DRAIN_CYCLES = 40;
  localparam int                 RANDOM_ITEMS = 700;
  localparam int                 GAP_MAX      = 17;
  localparam int                 TIMEOUT_NS   = 5_000_000;
  localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX      = 32'sh7FFF_FFFF;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [31:0] item_value;
  logic               out_valid;
  logic               out_ready;
  logic               found;
  logic               drained;
  int                 failures;

  // Stimulus-side view of the matrix, used to build the sorted fill and pick search targets.
  logic signed [31:0] shadow [16][16];
  bit                 written [16][16];
  int                 searches_sent;
  int                 results_taken;
  int                 items_sent;
  int                 last_er;
  int                 last_ec;
  bit                 tx_burst;
  bit                 rx_burst;

  sorted_matrix_staircase_search_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .row_index  (row_index),
    .col_index  (col_index),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found)
  );

  staircase_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .row_index  (row_index),
    .col_index  (col_index),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .drained    (drained),
    .failures   (failures)
  );

  always #5 clk = ~clk;

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic push_item(input action_e act, input logic [3:0] r, input logic [3:0] c,
                           input logic signed [31:0] v);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    row_index  <= r;
    col_index  <= c;
    item_value <= v;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_SEARCH) begin
      searches_sent++;
    end else begin
      shadow[r][c]  = v;
      written[r][c] = 1'b1;
    end
    items_sent++;
  endtask

  // Drop valid, wait for every search to be answered, then let the block sit idle for the drain time.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_taken != searches_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB write once the unit drains: setup phase, access phase, then an idle phase so psel can rise again.
  task automatic write_reg(input logic [2:0] addr, input logic [4:0] val);
    logic [31:0] word;
    wait_idle();
    word      = $urandom;
    word[4:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Set the counts, reload the region in use when needed (mostly sorted), then run
  // searches with a sprinkling of stray writes that may break the ordering.
  task automatic run_phase(input int nrows, input int ncols, input int nsearch);
    int                 er;
    int                 ec;
    int                 stepmax;
    int                 draw;
    int                 pr;
    int                 pc;
    bit                 refill;
    bit                 unsorted;
    longint             prev;
    longint             cand;
    longint             base;
    logic signed [31:0] v;
    write_reg(ADDR_ROWS_IN_USE, 5'(nrows));
    write_reg(ADDR_COLS_IN_USE, 5'(ncols));
    er = (nrows > SSS_MAX_ROWS) ? SSS_MAX_ROWS : nrows;
    ec = (ncols > SSS_MAX_COLS) ? SSS_MAX_COLS : ncols;
    refill = (er != last_er) || (ec != last_ec) || ($urandom_range(0, 2) == 0);
    for (int r = 0; r < er; r++)
      for (int c = 0; c < ec; c++)
        if (!written[r][c]) refill = 1'b1;
    last_er = er;
    last_ec = ec;
    if (refill) begin
      unsorted = ($urandom_range(0, 5) == 0);
      draw = $urandom_range(0, 2);
      stepmax = (draw == 0) ? 2 : (draw == 1) ? 1000 : (1 << 24);
      draw = $urandom_range(0, 3);
      if (draw == 0) base = VAL_MIN;
      else if (draw == 1) base = $signed($urandom_range(0, 100)) - 50;
      else base = $signed(32'($urandom));
      for (int r = 0; r < er; r++) begin
        for (int c = 0; c < ec; c++) begin
          if (r == 0 && c == 0) prev = base;
          else if (r == 0) prev = shadow[0][c-1];
          else if (c == 0) prev = shadow[r-1][0];
          else prev = (shadow[r-1][c] > shadow[r][c-1]) ? shadow[r-1][c] : shadow[r][c-1];
          cand = prev + $urandom_range(0, stepmax);
          if (cand > VAL_MAX) cand = VAL_MAX;
          v = unsorted ? $signed(32'($urandom)) : 32'(cand);
          push_item(ACT_WRITE, 4'(r), 4'(c), v);
        end
      end
    end
    for (int k = 0; k < nsearch; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(ACT_WRITE, 4'($urandom), 4'($urandom), $signed(32'($urandom)));
      end else begin
        draw = $urandom_range(0, 19);
        pr = (er > 0) ? $urandom_range(0, er - 1) : 0;
        pc = (ec > 0) ? $urandom_range(0, ec - 1) : 0;
        if (er == 0 || ec == 0 || draw >= 14 && draw <= 16) v = $signed(32'($urandom));
        else if (draw < 10) v = shadow[pr][pc];
        else if (draw < 14) v = shadow[pr][pc] + (draw[0] ? 32'sd1 : -32'sd1);
        else if (draw == 17) v = VAL_MIN;
        else if (draw == 18) v = VAL_MAX;
        else v = '0;
        push_item(ACT_SEARCH, 4'($urandom), 4'($urandom), v);
      end
    end
  endtask

  // Result side: stall a random number of cycles before each result, with runs of none.
  initial begin
    int gap;
    out_ready = 1'b0;
    results_taken = 0;
    rx_burst = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  initial begin
    int nr;
    int nc;
    int sel;
    clk        = 1'b0;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    action     = ACT_WRITE;
    row_index  = '0;
    col_index  = '0;
    item_value = '0;
    drained    = 1'b0;
    searches_sent = 0;
    items_sent = 0;
    tx_burst   = 1'b0;
    last_er    = 4;
    last_ec    = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset counts give a 4x4 matrix; corners hold the most negative and most
    // positive values, and two values each appear twice.
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        push_item(ACT_WRITE, 4'(r), 4'(c),
                  (r == 0 && c == 0) ? VAL_MIN : (r == 3 && c == 3) ? VAL_MAX :
                  32'(-100 + 30*r + 20*c));
    push_item(ACT_SEARCH, 4'd0, 4'd0, VAL_MIN);
    push_item(ACT_SEARCH, 4'd0, 4'd0, VAL_MAX);
    push_item(ACT_SEARCH, 4'd0, 4'd0, -32'sd40);
    push_item(ACT_SEARCH, 4'd0, 4'd0, -32'sd55);
    push_item(ACT_SEARCH, 4'd0, 4'd0, -32'sd150);
    push_item(ACT_SEARCH, 4'd0, 4'd0, 32'sd100);
    push_item(ACT_SEARCH, 4'hF, 4'hF, -32'sd1);

    // Extremes of the counts: single cell, full size, saturated counts, one row or column,
    // and zero rows or columns where the walk never starts.
    items_sent = 0;
    run_phase(1, 1, 12);
    run_phase(16, 16, 40);
    run_phase(31, 17, 20);
    run_phase(1, 16, 20);
    run_phase(16, 1, 20);
    run_phase(0, 6, 8);
    run_phase(7, 0, 8);
    run_phase(0, 0, 4);
    while (items_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        nr = $urandom_range(1, 5);
        nc = $urandom_range(1, 5);
      end else if (sel < 8) begin
        nr = $urandom_range(1, 16);
        nc = $urandom_range(1, 16);
      end else if (sel == 8) begin
        nr = $urandom_range(17, 31);
        nc = $urandom_range(1, 31);
      end else begin
        nr = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
        nc = (nr == 0) ? $urandom_range(0, 16) : 0;
      end
      run_phase(nr, nc, $urandom_range(10, 30));
    end

    // Drain, let the checker flag leftovers, then report.
    wait_idle();
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
